// ----- rtl/core/lzss_byte_stream_decoder_macros.svh -----
// Assertion macros shared by the LZSS decoder RTL.
`ifndef LZSS_BYTE_STREAM_DECODER_MACROS_SVH
`define LZSS_BYTE_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define LZSD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lzsd assertion failed");
// Condition must never be true outside reset.
`define LZSD_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("lzsd forbidden condition seen");
`else
`define LZSD_ASSERT(label, prop)
`define LZSD_ASSERT_NEVER(label, cond)
`endif

`endif

// ----- rtl/core/lzsd_pkg.sv -----
// Types and constants of the LZSS byte stream decoder.
package lzsd_pkg;

  localparam int BYTE_W  = 8;
  localparam int POS_W   = 15;
  localparam int DIST_W  = 13;
  localparam int CNT_W   = 5;
  localparam int FLAGS_W = 4;

  localparam logic [POS_W-1:0]   POS_MAX    = 15'h7fff;
  localparam logic [FLAGS_W-1:0] FLAG_COUNT = 4'd8;
  localparam logic [3:0]         NIBBLE_MASK = 4'hf;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    TOK_NONE,
    TOK_LITERAL,
    TOK_COPY
  } tok_kind_e;

  typedef struct packed {
    logic accept;
    logic rd;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    tok_kind_e kind;
    logic      last_byte;
    logic      out_free;
  } dp_status_t;

endpackage

// ----- rtl/core/lzsd_if.sv -----
// Stream channel interfaces for compressed input and decoded output beats.
interface lzsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       final_byte;

  modport source (output valid, output in_byte, output final_byte, input ready);
  modport sink   (input valid, input in_byte, input final_byte, output ready);
endinterface

interface lzsd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [14:0] out_position;
  logic        bad_reference;
  logic        run_last;

  modport source (output valid, output out_byte, output out_position,
                  output bad_reference, output run_last, input ready);
  modport sink   (input valid, input out_byte, input out_position,
                  input bad_reference, input run_last, output ready);
endinterface

// ----- rtl/core/lzsd_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module lzsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/lzsd_ctrl.sv -----
// Controller state machine of the LZSS decoder.
`include "lzss_byte_stream_decoder_macros.svh"

module lzsd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lzsd_pkg::dp_status_t status_i,
  output lzsd_pkg::ctrl_cmd_t  cmd_o
);

  lzsd_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lzsd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lzsd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.kind == lzsd_pkg::TOK_LITERAL) begin
            state_d = lzsd_pkg::ST_EMIT;
          end else if (status_i.kind == lzsd_pkg::TOK_COPY) begin
            state_d = lzsd_pkg::ST_READ;
          end
        end
      end
      lzsd_pkg::ST_READ: begin
        state_d = lzsd_pkg::ST_EMIT;
      end
      lzsd_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = status_i.last_byte ? lzsd_pkg::ST_IDLE : lzsd_pkg::ST_READ;
        end
      end
      default: state_d = lzsd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      lzsd_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      lzsd_pkg::ST_READ: begin
        cmd_o.rd = 1'b1;
      end
      lzsd_pkg::ST_EMIT: begin
        cmd_o.emit = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  `LZSD_ASSERT(a_read_then_emit, (state_q == lzsd_pkg::ST_READ) |=> (state_q == lzsd_pkg::ST_EMIT))
  `LZSD_ASSERT(a_copy_starts_read, (cmd_o.accept && status_i.kind == lzsd_pkg::TOK_COPY) |=> (state_q == lzsd_pkg::ST_READ))
  `LZSD_ASSERT(a_one_command, $onehot0({cmd_o.accept, cmd_o.rd, cmd_o.emit}))

endmodule

// ----- rtl/core/lzsd_datapath.sv -----
// Datapath of the LZSS decoder: token state, history window and output register.
`include "lzss_byte_stream_decoder_macros.svh"

module lzsd_datapath #(
  parameter int WINDOW_SIZE = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lzsd_pkg::ctrl_cmd_t    cmd_i,
  output lzsd_pkg::dp_status_t   status_o,
  input  logic [7:0]             in_byte_i,
  input  logic                   final_byte_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [7:0]             out_byte_o,
  output logic [14:0]            out_position_o,
  output logic                   bad_reference_o,
  output logic                   run_last_o
);

  localparam int AW = $clog2(WINDOW_SIZE);
  localparam int CW = AW + 1;
  localparam logic [AW-1:0] WPTR_LAST = AW'(WINDOW_SIZE - 1);
  localparam logic [CW-1:0] WIN_CW    = CW'(WINDOW_SIZE);

  // token state
  logic [7:0]                      flag_bits_q;
  logic [lzsd_pkg::FLAGS_W-1:0]    flags_left_q;
  logic                            half_pending_q;
  logic [3:0]                      held_len_q;
  logic [3:0]                      held_hi_q;
  logic [lzsd_pkg::POS_W-1:0]      produced_q;
  logic [AW-1:0]                   wptr_q;

  // current run
  logic [lzsd_pkg::DIST_W-1:0]     dist_q;
  logic [lzsd_pkg::CNT_W-1:0]      count_q;
  logic [7:0]                      lit_q;
  logic                            use_lit_q;
  logic                            bad_q;
  logic                            fin_q;

  // output register
  logic                            out_valid_q;
  logic [7:0]                      out_byte_q;
  logic [lzsd_pkg::POS_W-1:0]      out_pos_q;
  logic                            out_bad_q;
  logic                            out_last_q;

  logic [lzsd_pkg::FLAGS_W-1:0]    flags_left_m1;
  logic                            flag_sel;
  lzsd_pkg::tok_kind_e             kind;
  logic [CW-1:0]                   rd_diff;
  logic [CW-1:0]                   rd_wrapped;
  logic [AW-1:0]                   rd_addr;
  logic                            ref_bad;
  logic [7:0]                      ram_rdata;
  logic [7:0]                      emit_byte;
  logic                            last_byte;
  logic                            clear_stream;

  assign flags_left_m1 = flags_left_q - lzsd_pkg::FLAGS_W'(1);
  assign flag_sel      = flag_bits_q[flags_left_m1[2:0]];

  always_comb begin
    if (half_pending_q) begin
      kind = lzsd_pkg::TOK_COPY;
    end else if (flags_left_q == '0 || flag_sel) begin
      kind = lzsd_pkg::TOK_NONE;
    end else begin
      kind = lzsd_pkg::TOK_LITERAL;
    end
  end

  // read address: write pointer minus distance, modulo the window size
  assign rd_diff    = CW'(wptr_q) - CW'(dist_q);
  assign rd_wrapped = rd_diff + WIN_CW;
  assign rd_addr    = (CW'(wptr_q) >= CW'(dist_q)) ? rd_diff[AW-1:0] : rd_wrapped[AW-1:0];
  assign ref_bad    = lzsd_pkg::POS_W'(dist_q) > produced_q;

  assign last_byte  = (count_q == '0);
  assign emit_byte  = use_lit_q ? lit_q : (bad_q ? 8'h00 : ram_rdata);

  assign clear_stream = (cmd_i.accept && kind == lzsd_pkg::TOK_NONE && final_byte_i)
                     || (cmd_i.emit && last_byte && fin_q);

  lzsd_ram #(
    .WIDTH (lzsd_pkg::BYTE_W),
    .DEPTH (WINDOW_SIZE)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (cmd_i.emit),
    .waddr_i (wptr_q),
    .wdata_i (emit_byte),
    .re_i    (cmd_i.rd),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_bits_q    <= '0;
      flags_left_q   <= '0;
      half_pending_q <= 1'b0;
      held_len_q     <= '0;
      held_hi_q      <= '0;
      produced_q     <= '0;
      wptr_q         <= '0;
      count_q        <= '0;
      use_lit_q      <= 1'b0;
      bad_q          <= 1'b0;
      fin_q          <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cmd_i.accept) begin
        fin_q <= final_byte_i;
        unique case (kind)
          lzsd_pkg::TOK_COPY: begin
            half_pending_q <= 1'b0;
            dist_q    <= {1'b0, held_hi_q, in_byte_i} + lzsd_pkg::DIST_W'(1);
            count_q   <= lzsd_pkg::CNT_W'(held_len_q) + lzsd_pkg::CNT_W'(1);
            use_lit_q <= 1'b0;
          end
          lzsd_pkg::TOK_LITERAL: begin
            flags_left_q <= flags_left_m1;
            lit_q        <= in_byte_i;
            count_q      <= '0;
            use_lit_q    <= 1'b1;
            bad_q        <= 1'b0;
          end
          default: begin
            if (flags_left_q == '0) begin
              flag_bits_q  <= in_byte_i;
              flags_left_q <= lzsd_pkg::FLAG_COUNT;
            end else begin
              // flag bit set: hold the first reference half
              flags_left_q   <= flags_left_m1;
              held_len_q     <= in_byte_i[7:4];
              held_hi_q      <= in_byte_i[3:0] & lzsd_pkg::NIBBLE_MASK;
              half_pending_q <= 1'b1;
            end
          end
        endcase
      end

      if (cmd_i.rd) begin
        bad_q <= ref_bad;
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        wptr_q      <= (wptr_q == WPTR_LAST) ? '0 : wptr_q + AW'(1);
        if (produced_q != lzsd_pkg::POS_MAX) begin
          produced_q <= produced_q + lzsd_pkg::POS_W'(1);
        end
        count_q <= count_q - lzsd_pkg::CNT_W'(1);
      end

      if (clear_stream) begin
        flag_bits_q    <= '0;
        flags_left_q   <= '0;
        half_pending_q <= 1'b0;
        held_len_q     <= '0;
        held_hi_q      <= '0;
        produced_q     <= '0;
        wptr_q         <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q <= emit_byte;
      out_pos_q  <= produced_q;
      out_bad_q  <= use_lit_q ? 1'b0 : bad_q;
      out_last_q <= last_byte;
    end
  end

  assign status_o.kind      = kind;
  assign status_o.last_byte = last_byte;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign out_position_o  = out_pos_q;
  assign bad_reference_o = out_bad_q;
  assign run_last_o      = out_last_q;

  `LZSD_ASSERT(a_emit_fills_output, cmd_i.emit |=> out_valid_q)
  `LZSD_ASSERT(a_out_hold, (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_byte_q)))
  `LZSD_ASSERT_NEVER(a_flags_in_range, flags_left_q > lzsd_pkg::FLAG_COUNT)

endmodule

// ----- rtl/core/lzss_byte_stream_decoder.sv -----
// LZSS byte stream decoder top level: controller, datapath and channel hookup.
// Flag bytes and first reference halves take the idle state alone; a literal then
//   takes the emit state, and each byte of a back reference (2 to 17 bytes) a history
//   RAM read state and an emit-and-write state. No new beat is taken until a token is
//   done, and emits wait while the output register is full. A literal is held in the
//   datapath, a copied byte read from history RAM; both then fill the output register.
// Reset (rst_ni, async low) clears the token state, counters and output valid;
//   the history RAM is not cleared and needs no clearing pass.
module lzss_byte_stream_decoder #(
  parameter int WINDOW_SIZE = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lzsd_in_if.sink     in_i,
  lzsd_out_if.source  out_o
);

  // Command and status between the sequencer and the datapath.
  lzsd_pkg::ctrl_cmd_t  cmd;
  lzsd_pkg::dp_status_t status;

  // The controller only takes a beat while idle; one item is worked at a time.
  lzsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds flags, the pending reference half, the history window
  // and the output register, which parts the output beat from the sequencer.
  lzsd_datapath #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .in_byte_i       (in_i.in_byte),
    .final_byte_i    (in_i.final_byte),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .out_byte_o      (out_o.out_byte),
    .out_position_o  (out_o.out_position),
    .bad_reference_o (out_o.bad_reference),
    .run_last_o      (out_o.run_last)
  );

endmodule

// ----- tb/sv/lzss_byte_stream_decoder_test.sv -----
// Self-checking testbench for the LZSS byte stream decoder: directed tokens, long run, random streams.
`timescale 1ns / 1ps

module lzss_byte_stream_decoder_test;

  localparam int WINDOW_DEPTH = 4096;
  localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 50;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int PHASE_BEATS  = 18;
  localparam int MAX_REPORTS  = 50;
  localparam int TIMEOUT_NS   = 3_200_000;

  // Random phases: sender idle and receiver stall percentages.
  localparam int IDLE_MIX [4]  = '{0, 75, 0, 25};
  localparam int STALL_MIX [4] = '{0, 0, 75, 25};

  // One decoded byte as it leaves the output channel.
  typedef struct packed {
    logic [lzsd_pkg::BYTE_W-1:0] value;
    logic [lzsd_pkg::POS_W-1:0]  pos;
    logic                        bad;
    logic                        last;
  } out_beat_t;

  // One compressed beat; when typed is set, n bytes of value val starting at pos are expected.
  typedef struct packed {
    logic [lzsd_pkg::BYTE_W-1:0] b;
    logic                        fin;
    logic                        typed;
    logic [4:0]                  n;
    logic [lzsd_pkg::BYTE_W-1:0] val;
    logic [lzsd_pkg::POS_W-1:0]  pos;
    logic                        bad;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Testbench-side drivers of the channel inputs, known from time zero.
  logic                        tx_valid = 1'b0;
  logic [lzsd_pkg::BYTE_W-1:0] tx_byte  = '0;
  logic                        tx_last  = 1'b0;
  logic                        rx_ready = 1'b0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int beats_in       = 0;
  int bytes_checked  = 0;
  int err_count      = 0;

  // Decoder shadow state.
  logic [lzsd_pkg::BYTE_W-1:0]  flag_reg      = '0;
  logic [lzsd_pkg::FLAGS_W-1:0] tokens_left   = '0;
  logic                         ref_half_held = 1'b0;
  logic [3:0]                   ref_len_nib   = '0;
  logic [3:0]                   ref_dist_hi   = '0;
  logic [lzsd_pkg::POS_W-1:0]   byte_count    = '0;
  logic [ADDR_W-1:0]            wr_ptr        = '0;
  logic [lzsd_pkg::BYTE_W-1:0]  window_mem [WINDOW_DEPTH];

  out_beat_t step_q[$];    // bytes decoded from the beat just accepted
  out_beat_t expect_q[$];  // decoded bytes still owed by the block

  lzsd_in_if  in_ch ();
  lzsd_out_if out_ch ();

  assign in_ch.valid      = tx_valid;
  assign in_ch.in_byte    = tx_byte;
  assign in_ch.final_byte = tx_last;
  assign out_ch.ready     = rx_ready;

  lzss_byte_stream_decoder #(
    .WINDOW_SIZE(WINDOW_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Directed tokens. Stream one: flag 0x5A, literal/copy mix with short, long,
  // overlapping and out-of-reach copies. Stream two: flag 0xFF, copies whose
  // reach flips from bad to good inside one run, then a final beat that drops
  // a half-received reference. Streams three and four: positions restart from
  // zero after a final beat, and a copy from an empty history.
  localparam int DIR_ROWS = 25;
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{8'h5A, 1'b0, 1'b1, 5'd0,  8'h00, 15'd0,  1'b0},
    '{8'hFF, 1'b0, 1'b1, 5'd1,  8'hFF, 15'd0,  1'b0},
    '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00, 15'd0,  1'b0},
    '{8'h00, 1'b0, 1'b1, 5'd2,  8'hFF, 15'd1,  1'b0},
    '{8'h80, 1'b0, 1'b1, 5'd1,  8'h80, 15'd3,  1'b0},
    '{8'hF0, 1'b0, 1'b1, 5'd0,  8'h00, 15'd0,  1'b0},
    '{8'h03, 1'b0, 1'b0, 5'd0,  8'h00, 15'd0,  1'b0},
    '{8'h0F, 1'b0, 1'b1, 5'd0,  8'h00, 15'd0,  1'b0},
    '{8'hFF, 1'b0, 1'b1, 5'd2,  8'h00, 15'd21, 1'b1},
    '{8'h7F, 1'b0, 1'b1, 5'd1,  8'h7F, 15'd23, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 5'd0,  8'h00, 15'd0,  1'b0},
    '{8'hFF, 1'b0, 1'b1, 5'd17, 8'h00, 15'd24, 1'b1},
    '{8'h01, 1'b0, 1'b1, 5'd1,  8'h01, 15'd41, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 5'd0,  8'h00, 15'd0,  1'b0},
    '{8'h10, 1'b0, 1'b0, 5'd0,  8'h00, 15'd0,  1'b0},
    '{8'h15, 1'b0, 1'b0, 5'd0,  8'h00, 15'd0,  1'b0},
    '{8'h00, 1'b0, 1'b0, 5'd0,  8'h00, 15'd0,  1'b0},
    '{8'h2D, 1'b0, 1'b0, 5'd0,  8'h00, 15'd0,  1'b0},
    '{8'h30, 1'b1, 1'b1, 5'd0,  8'h00, 15'd0,  1'b0},
    '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00, 15'd0,  1'b0},
    '{8'hAA, 1'b0, 1'b1, 5'd1,  8'hAA, 15'd0,  1'b0},
    '{8'h55, 1'b1, 1'b1, 5'd1,  8'h55, 15'd1,  1'b0},
    '{8'h80, 1'b0, 1'b1, 5'd0,  8'h00, 15'd0,  1'b0},
    '{8'h00, 1'b0, 1'b0, 5'd0,  8'h00, 15'd0,  1'b0},
    '{8'h00, 1'b1, 1'b0, 5'd0,  8'h00, 15'd0,  1'b0}
  };

  // Append one decoded byte: write history, stamp the position, saturate the count.
  function automatic void emit_byte(input logic [lzsd_pkg::BYTE_W-1:0] v, input logic bad);
    window_mem[wr_ptr] = v;
    step_q.push_back({v, byte_count, bad, 1'b0});
    wr_ptr = wr_ptr + 1'b1;
    if (byte_count != lzsd_pkg::POS_MAX) byte_count = byte_count + 1'b1;
  endfunction

  // Decode one compressed byte into step_q and advance the shadow state.
  function automatic void decode_byte(input logic [lzsd_pkg::BYTE_W-1:0] b, input logic fin);
    logic [12:0]       copy_dist;
    logic [4:0]        run_len;
    logic [ADDR_W-1:0] rd_addr;
    out_beat_t         tail;
    step_q.delete();
    if (ref_half_held) begin
      copy_dist     = {1'b0, ref_dist_hi, b} + 13'd1;
      run_len       = {1'b0, ref_len_nib} + 5'd2;
      ref_half_held = 1'b0;
      // Copy byte by byte: an overlapping copy rereads bytes it just wrote,
      // and the reach check is redone for every byte.
      for (int i = 0; i < run_len; i++) begin
        if (copy_dist <= byte_count) begin
          rd_addr = wr_ptr - copy_dist[ADDR_W-1:0];
          emit_byte(window_mem[rd_addr], 1'b0);
        end else begin
          emit_byte('0, 1'b1);
        end
      end
    end else if (tokens_left == 0) begin
      flag_reg    = b;
      tokens_left = lzsd_pkg::FLAG_COUNT;
    end else begin
      tokens_left = tokens_left - 1'b1;
      if (flag_reg[tokens_left[2:0]]) begin
        ref_len_nib   = b[7:4];
        ref_dist_hi   = b[3:0];
        ref_half_held = 1'b1;
      end else begin
        emit_byte(b, 1'b0);
      end
    end
    if (step_q.size() > 0) begin
      tail      = step_q.pop_back();
      tail.last = 1'b1;
      step_q.push_back(tail);
    end
    // A final beat drops any partial token and restarts positions; history stays.
    if (fin) begin
      flag_reg      = '0;
      tokens_left   = '0;
      ref_half_held = 1'b0;
      ref_len_nib   = '0;
      ref_dist_hi   = '0;
      byte_count    = '0;
      wr_ptr        = '0;
    end
  endfunction

  // Offer one beat, hold it until accepted, then record what it must produce.
  task automatic send_beat(input stim_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      tx_valid <= 1'b0;
      tx_byte  <= 8'($urandom);
      @(negedge clk_i);
    end
    tx_valid <= 1'b1;
    tx_byte  <= row.b;
    tx_last  <= row.fin;
    do @(posedge clk_i); while (!(tx_valid && in_ch.ready));
    decode_byte(row.b, row.fin);
    if (row.typed) begin
      for (int k = 0; k < int'(row.n); k++)
        expect_q.push_back({row.val, row.pos + lzsd_pkg::POS_W'(k), row.bad,
                            k == int'(row.n) - 1});
    end else begin
      foreach (step_q[k]) expect_q.push_back(step_q[k]);
    end
    beats_in++;
    @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [lzsd_pkg::BYTE_W-1:0] b, input logic fin);
    stim_row_t row;
    row     = '0;
    row.b   = b;
    row.fin = fin;
    send_beat(row);
  endtask

  // Send a flag beat and its eight tokens. Copies mostly stay within the bytes
  // produced so far, favoring short distances so that runs overlap; far_pct of
  // them reach past the start of the stream.
  task automatic send_group(input int refs_pct, input int far_pct, input bit long_runs,
                            input bit close_stream);
    logic [7:0]        flags;
    logic [ADDR_W-1:0] code;
    logic [3:0]        len_nib;
    int                reach;
    int                pick_dist;
    bit                fin;
    for (int i = 0; i < 8; i++) flags[i] = ($urandom_range(99) < refs_pct);
    send_byte(flags, 1'b0);
    for (int t = 7; t >= 0; t--) begin
      fin = close_stream && (t == 0);
      if (flags[t]) begin
        reach = (int'(byte_count) < WINDOW_DEPTH) ? int'(byte_count) : WINDOW_DEPTH;
        if (reach < WINDOW_DEPTH && (reach == 0 || $urandom_range(99) < far_pct))
          pick_dist = $urandom_range(WINDOW_DEPTH, reach + 1);
        else if ($urandom_range(1) == 1)
          pick_dist = $urandom_range((reach < 8) ? reach : 8, 1);
        else
          pick_dist = $urandom_range(reach, 1);
        code    = ADDR_W'(pick_dist - 1);
        len_nib = long_runs ? 4'hF : 4'($urandom);
        send_byte({len_nib, code[11:8]}, 1'b0);
        send_byte(code[7:0], fin);
      end else begin
        send_byte(8'($urandom), fin);
      end
    end
  endtask

  // Receiver: drop ready at random, redrawn every falling edge.
  always @(negedge clk_i) begin
    rx_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Output checker: compare each accepted beat with the oldest owed byte.
  always @(posedge clk_i) begin
    out_beat_t got;
    out_beat_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = {out_ch.out_byte, out_ch.out_position, out_ch.bad_reference, out_ch.run_last};
      bytes_checked++;
      if (expect_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: unexpected byte %02h pos %0d bad %0b last %0b, nothing owed",
                   $time, got.value, got.pos, got.bad, got.last);
      end else begin
        want = expect_q.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: expected byte %02h pos %0d bad %0b last %0b,",
                     $time, want.value, want.pos, want.bad, want.last,
                     " got byte %02h pos %0d bad %0b last %0b",
                     got.value, got.pos, got.bad, got.last);
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int pick;
    int n;
    int phase_mark;
    int wait_cycles;

    // Hold reset, then release on a falling edge.
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed tokens, no idling.
    foreach (dir_rows[i]) send_beat(dir_rows[i]);

    // Long stream: seed with literals, then a group of full-length copies
    // that overlap freely, and close the stream with a mixed group.
    send_group(0, 0, 1'b0, 1'b0);
    send_group(100, 0, 1'b1, 1'b0);
    send_group(50, 10, 1'b0, 1'b1);

    // Random streams under each idle/stall mix. Most traffic is well-formed
    // groups; the rest is noise or a group cut short, both closed by a final
    // beat so that the next group starts on a flag byte.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = IDLE_MIX[p];
      recv_stall_pct = STALL_MIX[p];
      phase_mark     = beats_in;
      while (beats_in - phase_mark < PHASE_BEATS) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          send_group($urandom_range(100), 10, 1'b0, $urandom_range(99) < 25);
        end else if (pick < 85) begin
          n = $urandom_range(6, 1);
          for (int i = 0; i < n; i++)
            send_byte(8'($urandom), (i == n - 1) || ($urandom_range(9) == 0));
        end else begin
          n = $urandom_range(4, 1);
          send_byte(8'($urandom), 1'b0);
          for (int i = 0; i < n; i++) send_byte(8'($urandom), i == n - 1);
        end
      end
    end
    tx_valid <= 1'b0;

    // Drain: wait for every owed byte, then watch for strays.
    wait_cycles = 0;
    while (expect_q.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expect_q.size() != 0) begin
      err_count++;
      $display("%0t: %0d decoded bytes never arrived", $time, expect_q.size());
    end

    $display("Sent %0d compressed beats, checked %0d decoded bytes, %0d mismatches.",
             beats_in, bytes_checked, err_count);
    $display("Covered literals, overlapping and out-of-reach copies, stream restarts",
             " and four idle/stall mixes.");
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
